// ===== rtl/iregcs_pkg.sv =====
// Package for the indexed register block: port and register index codes,
// reset values and the control struct passed from the register file to the top.
// No dependencies.
package iregcs_pkg;

	localparam logic [15:0] PORT_INDEX = 16'h0022;
	localparam logic [15:0] PORT_DATA  = 16'h0024;

	localparam logic [7:0] REG_POWER     = 8'hea;
	localparam logic [7:0] REG_BASE_HIGH = 8'hf7;
	localparam logic [7:0] REG_BASE_LOW  = 8'hf8;
	localparam logic [7:0] REG_CONTROL   = 8'hf9;
	localparam logic [7:0] REG_GPM       = 8'hfa;

	// Bit positions in the control register.
	localparam int CTRL_MERGE_BIT = 6;
	localparam int CTRL_NVR_BIT   = 5;
	localparam int CTRL_SIZE_HI   = 4;
	localparam int CTRL_SIZE_LO   = 2;

	localparam logic [7:0] GPM_RESET    = 8'h07;
	localparam logic [7:0] ENTRY1_RESET = 8'hfe;
	localparam logic [7:0] UNDECODED    = 8'hff;

	// Widest window is 128 bytes, so the offset is seven bits.
	localparam int OFFSET_W = 7;

	typedef enum logic {
		SRC_PORT,
		SRC_STORE
	} rd_src_t;

	typedef struct packed {
		logic                hit;       // access hit the index or data port
		logic [7:0]          rdata;     // read value for a port access
		logic [15:0]         win_base;  // aligned window base
		logic [OFFSET_W-1:0] win_mask;  // window size minus one
		logic                nvr;       // NVR bank after this access
	} port_ctl_t;

endpackage

// ===== rtl/iregcs_if.sv =====
// Handshake interfaces for bus access words and result words.
// Depends on nothing.
interface iregcs_req_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [15:0] port_address;
	logic [7:0]  write_data;

	modport source (output valid, cmd, port_address, write_data, input ready);
	modport sink   (input valid, cmd, port_address, write_data, output ready);
endinterface

interface iregcs_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       claimed;
	logic       nvr_bank;

	modport source (output valid, read_data, claimed, nvr_bank, input ready);
	modport sink   (input valid, read_data, claimed, nvr_bank, output ready);
endinterface

// ===== rtl/iregcs_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module iregcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                    wdata,
	input  logic                                re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                    rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/iregcs_regs.sv =====
// Index latch and the five indexed registers behind the data port.
// Depends on iregcs_pkg.
module iregcs_regs (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic                  cmd,
	input  logic [15:0]           port_address,
	input  logic [7:0]            write_data,
	output iregcs_pkg::port_ctl_t ctl
);

	logic [7:0] index_q;
	logic [7:0] power_q;
	logic [7:0] base_high_q;
	logic [7:0] base_low_q;
	logic [7:0] control_q;
	logic [7:0] gpm_q;

	logic       index_hit;
	logic       data_hit;
	logic       data_wr;
	logic [7:0] reg_rdata;
	logic [7:0] size_mask;

	assign index_hit = (port_address == iregcs_pkg::PORT_INDEX);
	assign data_hit  = (port_address == iregcs_pkg::PORT_DATA);
	assign data_wr   = accept && data_hit && cmd;

	always_comb begin
		case (index_q)
			iregcs_pkg::REG_POWER:     reg_rdata = power_q;
			iregcs_pkg::REG_BASE_HIGH: reg_rdata = base_high_q;
			iregcs_pkg::REG_BASE_LOW:  reg_rdata = base_low_q;
			iregcs_pkg::REG_CONTROL:   reg_rdata = control_q;
			iregcs_pkg::REG_GPM: begin
				if (control_q[iregcs_pkg::CTRL_MERGE_BIT]) begin
					reg_rdata = gpm_q | power_q;
				end else begin
					reg_rdata = gpm_q;
				end
			end
			default:                   reg_rdata = iregcs_pkg::UNDECODED;
		endcase
	end

	// Window size is a power of two from one to 128 bytes.
	assign size_mask = (8'd1 << control_q[iregcs_pkg::CTRL_SIZE_HI:iregcs_pkg::CTRL_SIZE_LO])
		- 8'd1;

	always_comb begin
		ctl.hit      = index_hit || data_hit;
		ctl.rdata    = data_hit ? reg_rdata : iregcs_pkg::UNDECODED;
		ctl.win_mask = size_mask[iregcs_pkg::OFFSET_W-1:0];
		ctl.win_base = {base_high_q, base_low_q} & ~{9'd0, ctl.win_mask};
		if (data_wr && index_q == iregcs_pkg::REG_CONTROL) begin
			ctl.nvr = write_data[iregcs_pkg::CTRL_NVR_BIT];
		end else begin
			ctl.nvr = control_q[iregcs_pkg::CTRL_NVR_BIT];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q     <= '0;
			power_q     <= '0;
			base_high_q <= '0;
			base_low_q  <= '0;
			control_q   <= '0;
			gpm_q       <= iregcs_pkg::GPM_RESET;
		end else begin
			if (accept && index_hit && cmd) begin
				index_q <= write_data;
			end
			if (data_wr) begin
				case (index_q)
					iregcs_pkg::REG_POWER:     power_q     <= write_data;
					iregcs_pkg::REG_BASE_HIGH: base_high_q <= write_data;
					iregcs_pkg::REG_BASE_LOW:  base_low_q  <= write_data;
					iregcs_pkg::REG_CONTROL:   control_q   <= write_data;
					iregcs_pkg::REG_GPM:       gpm_q       <= write_data;
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== rtl/indexed_regs_with_chip_select_window.sv =====
// Indexed configuration registers with a chip select window over a byte store.
// Depends on iregcs_pkg, iregcs_if, iregcs_regs and iregcs_ram.
//
// The block takes one bus access word per clock cycle on req while rsp is not
// stalled, and returns one result word for each on rsp. All register and store
// updates take effect at the edge that accepts the word, so the next word already
// sees them. A result passes the decode stage registers, which sit beside the
// registered read of the window store, and then an output register, which lets
// the block keep accepting words while a result waits to be taken. The store
// powers up reading zero everywhere except entry one, which reads 0xfe; a valid
// bit for each entry provides this, so no clearing pass is needed after reset.
module indexed_regs_with_chip_select_window #(
	parameter int STORE_DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	iregcs_req_if.sink         req,
	iregcs_rsp_if.source       rsp
);

	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	iregcs_pkg::port_ctl_t ctl;

	logic                            accept;
	logic                            advance;
	logic                            win_hit;
	logic [iregcs_pkg::OFFSET_W-1:0] win_off;
	logic                            in_store;
	logic [AW-1:0]                   store_idx;
	logic                            store_wr;
	logic                            store_rd;
	logic [7:0]                      ram_rdata;
	logic [7:0]                      pre_rdata;
	logic [7:0]                      rst_val;

	logic [STORE_DEPTH-1:0] store_vld_q;

	// Decode stage registers.
	logic                 valid_s1;
	logic                 wr_s1;
	logic                 claimed_s1;
	iregcs_pkg::rd_src_t  src_s1;
	logic [7:0]           rdata_s1;
	logic                 vld_s1;
	logic [7:0]           rst_val_s1;
	logic                 nvr_s1;

	// Output register.
	logic       out_valid_q;
	logic [7:0] read_data_q;
	logic       claimed_q;
	logic       nvr_bank_q;

	logic [7:0] final_rdata;

	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign accept    = req.valid && req.ready;

	iregcs_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.cmd          (req.cmd),
		.port_address (req.port_address),
		.write_data   (req.write_data),
		.ctl          (ctl)
	);

	// The base is aligned to the window size, so an address falls inside the
	// window exactly when its upper bits match the base. A zero base disables
	// the window, and the index ports always win over it.
	assign win_hit = !ctl.hit && (ctl.win_base != 16'd0)
		&& ((req.port_address & ~{9'd0, ctl.win_mask}) == ctl.win_base);
	assign win_off   = req.port_address[iregcs_pkg::OFFSET_W-1:0] & ctl.win_mask;
	assign in_store  = win_hit && ({1'b0, win_off} < 8'(STORE_DEPTH));
	assign store_idx = AW'(win_off);
	assign store_wr  = accept && in_store && req.cmd;
	assign store_rd  = accept && in_store && !req.cmd;

	// An offset inside the window but beyond the store reads as undecoded.
	assign pre_rdata = ctl.hit ? ctl.rdata : iregcs_pkg::UNDECODED;
	assign rst_val   = (win_off == iregcs_pkg::OFFSET_W'(1)) ? iregcs_pkg::ENTRY1_RESET : 8'd0;

	iregcs_ram #(
		.WIDTH (8),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (store_wr),
		.waddr (store_idx),
		.wdata (req.write_data),
		.re    (store_rd),
		.raddr (store_idx),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_vld_q <= '0;
		end else if (store_wr) begin
			store_vld_q[store_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wr_s1      <= req.cmd;
			claimed_s1 <= ctl.hit || win_hit;
			src_s1     <= in_store ? iregcs_pkg::SRC_STORE : iregcs_pkg::SRC_PORT;
			rdata_s1   <= pre_rdata;
			vld_s1     <= store_vld_q[store_idx];
			rst_val_s1 <= rst_val;
			nvr_s1     <= ctl.nvr;
		end
	end

	always_comb begin
		if (wr_s1) begin
			final_rdata = 8'd0;
		end else if (src_s1 == iregcs_pkg::SRC_STORE) begin
			final_rdata = vld_s1 ? ram_rdata : rst_val_s1;
		end else begin
			final_rdata = rdata_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q <= final_rdata;
			claimed_q   <= claimed_s1;
			nvr_bank_q  <= nvr_s1;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.read_data = read_data_q;
	assign rsp.claimed   = claimed_q;
	assign rsp.nvr_bank  = nvr_bank_q;

endmodule

// ===== sim/indexed_regs_with_chip_select_window_tb.sv =====
// Self-checking testbench for indexed_regs_with_chip_select_window: bus access words
// are driven on req, and every result word on rsp is checked against a scoreboard.
// Depends on iregcs_pkg, iregcs_if and the block itself.
module indexed_regs_with_chip_select_window_tb;
	import iregcs_pkg::*;

	localparam int STORE_DEPTH    = 32;
	localparam int RANDOM_WORDS   = 400;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int DRAIN_CYCLES   = 20;
	// The receiver stops taking results for this long, once, after this many results.
	localparam int HOLD_AFTER     = 150;
	localparam int HOLD_CYCLES    = 400;

	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// What the block should return for one access word.
	typedef struct {
		logic [7:0] rdata;
		logic       claimed;
		logic       nvr;
	} reply_t;

	// The scoreboard keeps its own copy of the register file and of the byte store. Each
	// accepted access updates that copy and queues the reply that the block owes for it.
	class decode_scoreboard;
		logic [7:0] index_q, power_q, base_hi_q, base_lo_q, ctrl_q, gpm_q;
		logic [7:0] store_q [STORE_DEPTH];
		reply_t     replies_due [$];
		int         errors, checked;
		int         n_port, n_window, n_beyond, n_merged, n_unclaimed;

		function new();
			index_q   = 8'h00;
			power_q   = 8'h00;
			base_hi_q = 8'h00;
			base_lo_q = 8'h00;
			ctrl_q    = 8'h00;
			gpm_q     = GPM_RESET;
			foreach (store_q[i])
				store_q[i] = 8'h00;
			if (STORE_DEPTH > 1)
				store_q[1] = ENTRY1_RESET;
			errors      = 0;
			checked     = 0;
			n_port      = 0;
			n_window    = 0;
			n_beyond    = 0;
			n_merged    = 0;
			n_unclaimed = 0;
		endfunction

		function int unsigned win_size();
			return 1 << ctrl_q[CTRL_SIZE_HI:CTRL_SIZE_LO];
		endfunction

		// The base is aligned down to the window size.
		function logic [15:0] win_base();
			logic [15:0] mask;
			mask = 16'(win_size() - 1);
			return {base_hi_q, base_lo_q} & ~mask;
		endfunction

		function int pending();
			return replies_due.size();
		endfunction

		function logic [7:0] reg_value();
			case (index_q)
				REG_POWER:     return power_q;
				REG_BASE_HIGH: return base_hi_q;
				REG_BASE_LOW:  return base_lo_q;
				REG_CONTROL:   return ctrl_q;
				REG_GPM: begin
					if (ctrl_q[CTRL_MERGE_BIT]) begin
						n_merged++;
						return gpm_q | power_q;
					end
					return gpm_q;
				end
				default:       return UNDECODED;
			endcase
		endfunction

		function void reg_store(logic [7:0] wdata);
			case (index_q)
				REG_POWER:     power_q   = wdata;
				REG_BASE_HIGH: base_hi_q = wdata;
				REG_BASE_LOW:  base_lo_q = wdata;
				REG_CONTROL:   ctrl_q    = wdata;
				REG_GPM:       gpm_q     = wdata;
				default:       ;
			endcase
		endfunction

		function void note_access(logic cmd, logic [15:0] addr, logic [7:0] wdata);
			reply_t      r;
			int unsigned a, b, size, off;
			a         = addr;
			b         = win_base();
			size      = win_size();
			r.rdata   = UNDECODED;
			r.claimed = 1'b0;
			if (addr == PORT_INDEX) begin
				r.claimed = 1'b1;
				n_port++;
				if (cmd == CMD_WRITE)
					index_q = wdata;
			end else if (addr == PORT_DATA) begin
				r.claimed = 1'b1;
				n_port++;
				if (cmd == CMD_WRITE)
					reg_store(wdata);
				else
					r.rdata = reg_value();
			end else if (b != 0 && a >= b && (a - b) < size) begin
				off       = a - b;
				r.claimed = 1'b1;
				n_window++;
				if (off < STORE_DEPTH) begin
					if (cmd == CMD_WRITE)
						store_q[off] = wdata;
					else
						r.rdata = store_q[off];
				end else begin
					n_beyond++;
				end
			end else begin
				n_unclaimed++;
			end
			if (cmd == CMD_WRITE)
				r.rdata = 8'h00;
			r.nvr = ctrl_q[CTRL_NVR_BIT];
			replies_due.push_back(r);
		endfunction

		function void check_reply(logic [7:0] rdata, logic claimed, logic nvr);
			reply_t e;
			if (replies_due.size() == 0) begin
				$display("%0t: unexpected result: read_data %02h claimed %0b nvr_bank %0b",
					$time, rdata, claimed, nvr);
				errors++;
				return;
			end
			e = replies_due.pop_front();
			checked++;
			if (rdata !== e.rdata) begin
				$display("%0t: read_data expected %02h, got %02h", $time, e.rdata, rdata);
				errors++;
			end
			if (claimed !== e.claimed) begin
				$display("%0t: claimed expected %0b, got %0b", $time, e.claimed, claimed);
				errors++;
			end
			if (nvr !== e.nvr) begin
				$display("%0t: nvr_bank expected %0b, got %0b", $time, e.nvr, nvr);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   calm;        // while set, neither side inserts random idle cycles
	int   words_sent;
	int   cycles;

	decode_scoreboard sb = new();

	iregcs_req_if req_bus ();
	iregcs_rsp_if rsp_bus ();

	indexed_regs_with_chip_select_window #(
		.STORE_DEPTH(STORE_DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_bus),
		.rsp   (rsp_bus)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// A watchdog on the whole run; a hung handshake ends here.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Timed out after %0d cycles with %0d results outstanding.",
					cycles, sb.pending());
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Idle length for either side: mostly none, often short, now and then a long one.
	function automatic int pick_pause();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offers one access word and waits for the edge that accepts it. The caller is
	// always just past a rising edge. After acceptance the sender may idle; valid is
	// only lowered when it does, so it is never lowered and raised in the same step.
	task automatic send_word(logic cmd, logic [15:0] addr, logic [7:0] wdata);
		int gap;
		req_bus.valid        <= 1'b1;
		req_bus.cmd          <= cmd;
		req_bus.port_address <= addr;
		req_bus.write_data   <= wdata;
		do
			@(posedge clk);
		while (!req_bus.ready);
		sb.note_access(cmd, addr, wdata);
		words_sent++;
		gap = pick_pause();
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// An indexed register access: latch the index, then touch the data port.
	task automatic reg_access(logic cmd, logic [7:0] index, logic [7:0] wdata);
		send_word(CMD_WRITE, PORT_INDEX, index);
		send_word(cmd, PORT_DATA, wdata);
	endtask

	// One random step. Most of them are well-formed: an index followed by a data port
	// access, or an access that lands inside the current window (usually within the
	// store, sometimes past it or just outside). The rest is noise over the whole
	// address space and odd accesses to the index ports themselves.
	task automatic random_access();
		int            r, pick;
		logic [7:0]    index;
		int unsigned   size, reach;
		logic [15:0]   base, addr;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			pick = $urandom_range(0, 9);
			case (pick)
				0, 1:    index = REG_POWER;
				2:       index = REG_BASE_HIGH;
				3:       index = REG_BASE_LOW;
				4, 5:    index = REG_CONTROL;
				6, 7:    index = REG_GPM;
				default: index = 8'($urandom_range(0, 255));
			endcase
			reg_access(1'($urandom_range(0, 1)), index, 8'($urandom_range(0, 255)));
		end else if (r < 75) begin
			base = sb.win_base();
			size = sb.win_size();
			if (base == 16'h0000) begin
				// The window is off; give it a base so that later steps can use it.
				reg_access(CMD_WRITE, REG_BASE_HIGH, 8'($urandom_range(1, 255)));
			end else begin
				reach = (size < STORE_DEPTH) ? size : STORE_DEPTH;
				pick  = $urandom_range(0, 9);
				if (pick < 7)
					addr = base + 16'($urandom_range(0, reach - 1));
				else if (pick < 9)
					addr = base + 16'($urandom_range(0, size - 1));
				else if ($urandom_range(0, 1) == 1)
					addr = base - 16'd1;
				else
					addr = base + 16'(size);
				send_word(1'($urandom_range(0, 1)), addr, 8'($urandom_range(0, 255)));
			end
		end else if (r < 85) begin
			addr = ($urandom_range(0, 1) == 1) ? PORT_DATA : PORT_INDEX;
			send_word(1'($urandom_range(0, 1)), addr, 8'($urandom_range(0, 255)));
		end else begin
			send_word(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
				8'($urandom_range(0, 255)));
		end
	endtask

	// Result side. Takes results with random stalls, and once, after a fair number of
	// results, holds off for a long stretch so that the block fills up and stops
	// taking access words while the sender keeps offering them.
	initial begin : result_sink
		int  stall_left;
		int  gap;
		bit  held;
		stall_left = 0;
		held       = 1'b0;
		rsp_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_bus.valid && rsp_bus.ready)
				sb.check_reply(rsp_bus.read_data, rsp_bus.claimed, rsp_bus.nvr_bank);
			if (!held && sb.checked >= HOLD_AFTER) begin
				held       = 1'b1;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_bus.ready <= 1'b0;
			end else begin
				gap = pick_pause();
				if (gap > 0) begin
					stall_left = gap - 1;
					rsp_bus.ready <= 1'b0;
				end else begin
					rsp_bus.ready <= 1'b1;
				end
			end
		end
	end

	initial begin : access_source
		int directed_words;
		calm       = 1'b0;
		words_sent = 0;
		arst_n     = 1'b0;
		req_bus.valid        <= 1'b0;
		req_bus.cmd          <= CMD_READ;
		req_bus.port_address <= 16'h0000;
		req_bus.write_data   <= 8'h00;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Straight out of reset: a read of the index port, a read through
		// the data port with index zero (not one of the five registers), and an address
		// that nothing claims while the base is zero.
		send_word(CMD_READ, PORT_INDEX, 8'h00);
		send_word(CMD_READ, PORT_DATA, 8'h00);
		send_word(CMD_READ, 16'h0001, 8'h00);
		// Reset value of the general purpose register, then a write to the power register.
		reg_access(CMD_READ, REG_GPM, 8'h00);
		reg_access(CMD_WRITE, REG_POWER, 8'h30);
		// Merge and NVR bank on, eight byte window; read the control register back.
		send_word(CMD_WRITE, PORT_INDEX, REG_CONTROL);
		send_word(CMD_WRITE, PORT_DATA, 8'h6c);
		send_word(CMD_READ, PORT_DATA, 8'h00);
		// The merged read of the general purpose register ORs in the power register.
		reg_access(CMD_READ, REG_GPM, 8'h00);
		// A base of 0x23 aligns down to 0x20, so the window covers both index ports.
		// Inside it the store answers, but the ports keep their own meaning.
		reg_access(CMD_WRITE, REG_BASE_LOW, 8'h23);
		send_word(CMD_READ, 16'h0021, 8'h00);
		send_word(CMD_READ, PORT_DATA, 8'h00);
		send_word(CMD_WRITE, 16'h0027, 8'h5a);
		send_word(CMD_READ, 16'h0027, 8'h00);
		// Top of the address space with the widest window: base 0xff00, 128 bytes, of
		// which only the first STORE_DEPTH are backed by the store.
		reg_access(CMD_WRITE, REG_BASE_HIGH, 8'hff);
		reg_access(CMD_WRITE, REG_CONTROL, 8'h1c);
		send_word(CMD_WRITE, 16'hff7f, 8'hff);
		send_word(CMD_READ, 16'hff7f, 8'h00);
		send_word(CMD_READ, 16'hff01, 8'h00);
		send_word(CMD_READ, 16'hfeff, 8'h00);
		directed_words = words_sent;

		// Random part, with a calm stretch in every two hundred words.
		while (words_sent < directed_words + RANDOM_WORDS) begin
			calm = ((words_sent / 50) % 4) == 3;
			random_access();
		end
		calm = 1'b0;
		req_bus.valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d result words for %0d access words in %0d cycles.",
			sb.checked, words_sent, cycles);
		$display("Port %0d, window %0d (%0d beyond store), merged reads %0d, unclaimed %0d.",
			sb.n_port, sb.n_window, sb.n_beyond, sb.n_merged, sb.n_unclaimed);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
